[rtl/mst_pkg.sv]
package mst_pkg;

   // Field and table widths
   localparam int MOD_W    = 12;
   localparam int RES_W    = 12;
   localparam int ROOT_W   = 11;
   localparam int ENTRY_W  = 12;
   localparam int STATUS_W = 3;

   localparam int DEF_TABLE_DEPTH = 4096;

   // Table entry that marks a residue without a root
   localparam logic [ENTRY_W-1:0] NO_ROOT = 12'hFFF;

   // Modulus register reset value and largest modulus rejected as too small
   localparam logic [MOD_W-1:0] MOD_RESET = 12'd7;
   localparam logic [MOD_W-1:0] MOD_MIN_BAD = 12'd3;

   // Item action codes
   localparam logic ACT_BUILD = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 3'd0,
      STATUS_NONRES   = 3'd1,
      STATUS_RANGE    = 3'd2,
      STATUS_BADMOD   = 3'd3,
      STATUS_NOTBUILT = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      SEQ_IDLE  = 4'b0001,
      SEQ_CLEAR = 4'b0010,
      SEQ_FILL  = 4'b0100,
      SEQ_QREAD = 4'b1000
   } seq_state_type;

   // Control from the sequencer to the square stepper
   typedef struct packed {
      logic init;
      logic advance;
   } step_ctl_type;

endpackage

[rtl/mst_sqstep.sv]
module mst_sqstep
   import mst_pkg::*;
(
   input  logic               clock,
   input  step_ctl_type       ctl,
   input  logic [MOD_W-1:0]   modulus,
   output logic [ROOT_W-1:0]  y,
   output logic [MOD_W-1:0]   r,
   output logic               last
);

   logic [ROOT_W-1:0] y_ff, y_in;
   logic [MOD_W-1:0]  r_ff, r_in;
   logic [MOD_W-1:0]  odd;
   logic [MOD_W:0]    sum;
   logic [MOD_W:0]    wrapped;

   // Next square: (y+1)^2 = y^2 + 2y + 1, reduced by one compare and subtract
   always_comb begin
      odd     = {y_ff, 1'b1};
      sum     = {1'b0, r_ff} + {1'b0, odd};
      wrapped = (sum >= {1'b0, modulus}) ? (sum - {1'b0, modulus}) : sum;
      y_in    = y_ff;
      r_in    = r_ff;
      if (ctl.init) begin
         y_in = '0;
         r_in = '0;
      end else if (ctl.advance) begin
         y_in = y_ff + ROOT_W'(1);
         r_in = wrapped[MOD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      y_ff <= y_in;
      r_ff <= r_in;
   end

   assign y    = y_ff;
   assign r    = r_ff;
   assign last = (y_ff == modulus[MOD_W-1:1]);

endmodule

[rtl/modular_square_root_table_top.sv]
// Channel    | Ports                                         | Handshake
// -----------+-----------------------------------------------+------------------------
// request    | req_action, req_residue                       | start high, busy low
// response   | rsp_status, rsp_root, rsp_other_root          | rsp_strobe, one cycle
// config     | csr_wr_data                                   | csr_wr_en
//
// A query passes through one registered table read, then the result register.
// A build with a valid modulus m clears entries 0 to m-1, then writes y = 0 to m/2,
// one table write per cycle through the single write port; a rejected build writes none.
// Reset clears the sequencer, built flag and built modulus and sets the modulus register
// to 7; table entries are only read below the built modulus, which the build always rewrites.
// The receiver cannot stall: each item is on the rsp_ ports for exactly one cycle.
module modular_square_root_table_top
   import mst_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_action,
   input  logic [RES_W-1:0]    req_residue,
   input  logic                csr_wr_en,
   input  logic [MOD_W-1:0]    csr_wr_data,
   output logic                rsp_strobe,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ROOT_W-1:0]   rsp_root,
   output logic [MOD_W-1:0]    rsp_other_root
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int WIDE_W = ADDR_W + MOD_W;

   seq_state_type     state_ff, state_in;
   logic [MOD_W-1:0]  modulus_ff, modulus_in;
   logic [MOD_W-1:0]  built_mod_ff, built_mod_in;
   logic              built_ff, built_in;
   logic [MOD_W-1:0]  cnt_ff, cnt_in;
   logic [RES_W-1:0]  res_ff, res_in;

   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ROOT_W-1:0]   rsp_root_ff, rsp_root_in;
   logic [MOD_W-1:0]    rsp_other_ff, rsp_other_in;

   logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               we;
   logic [MOD_W-1:0]   waddr;
   logic [ENTRY_W-1:0] wdata;
   logic [WIDE_W-1:0]  waddr_wide;
   logic [WIDE_W-1:0]  raddr_wide;

   step_ctl_type       step_ctl;
   logic [ROOT_W-1:0]  step_y;
   logic [MOD_W-1:0]   step_r;
   logic               step_last;

   logic accept;
   logic mod_bad;

   mst_sqstep u_sqstep (
      .clock   (clock),
      .ctl     (step_ctl),
      .modulus (built_mod_ff),
      .y       (step_y),
      .r       (step_r),
      .last    (step_last)
   );

   assign busy   = (state_ff != SEQ_IDLE);
   assign accept = start && !busy;
   assign mod_bad = (modulus_ff <= MOD_MIN_BAD) || !modulus_ff[0] ||
                    (32'(modulus_ff) > 32'(TABLE_DEPTH));

   // Sequence builds and queries
   always_comb begin
      state_in      = state_ff;
      modulus_in    = modulus_ff;
      built_mod_in  = built_mod_ff;
      built_in      = built_ff;
      cnt_in        = cnt_ff;
      res_in        = res_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_root_in   = '0;
      rsp_other_in  = '0;
      step_ctl      = '0;
      we            = 1'b0;
      waddr         = cnt_ff;
      wdata         = NO_ROOT;

      if (csr_wr_en) begin
         modulus_in = csr_wr_data;
      end

      case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               if (req_action == ACT_QUERY) begin
                  res_in   = req_residue;
                  state_in = SEQ_QREAD;
               end else if (mod_bad) begin
                  built_in      = 1'b0;
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STATUS_BADMOD;
               end else begin
                  built_in      = 1'b0;
                  built_mod_in  = modulus_ff;
                  cnt_in        = '0;
                  step_ctl.init = 1'b1;
                  state_in      = SEQ_CLEAR;
               end
            end
         end
         SEQ_CLEAR: begin
            // Mark every entry below the modulus as having no root
            we = 1'b1;
            if (cnt_ff == built_mod_ff - MOD_W'(1)) begin
               state_in = SEQ_FILL;
            end else begin
               cnt_in = cnt_ff + MOD_W'(1);
            end
         end
         SEQ_FILL: begin
            // Write y at y*y mod m; a later y overwrites an earlier one
            we    = 1'b1;
            waddr = step_r;
            wdata = ENTRY_W'(step_y);
            if (step_last) begin
               built_in      = 1'b1;
               rsp_strobe_in = 1'b1;
               rsp_status_in = STATUS_OK;
               state_in      = SEQ_IDLE;
            end else begin
               step_ctl.advance = 1'b1;
            end
         end
         SEQ_QREAD: begin
            rsp_strobe_in = 1'b1;
            state_in      = SEQ_IDLE;
            if (!built_ff) begin
               rsp_status_in = STATUS_NOTBUILT;
            end else if ((res_ff >= built_mod_ff) ||
                         (32'(res_ff) >= 32'(TABLE_DEPTH))) begin
               rsp_status_in = STATUS_RANGE;
            end else if (rd_data_ff == NO_ROOT) begin
               rsp_status_in = STATUS_NONRES;
            end else begin
               rsp_status_in = STATUS_OK;
               rsp_root_in   = rd_data_ff[ROOT_W-1:0];
               rsp_other_in  = (rd_data_ff == '0) ? '0 : (built_mod_ff - rd_data_ff);
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SEQ_IDLE;
         modulus_ff    <= MOD_RESET;
         built_mod_ff  <= '0;
         built_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         modulus_ff    <= modulus_in;
         built_mod_ff  <= built_mod_in;
         built_ff      <= built_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      res_ff        <= res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_root_ff   <= rsp_root_in;
      rsp_other_ff  <= rsp_other_in;
   end

   // Root table: one write port, one registered read port
   assign waddr_wide = WIDE_W'(waddr);
   assign raddr_wide = WIDE_W'(req_residue);

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr_wide[ADDR_W-1:0]] <= wdata;
      end
      rd_data_ff <= mem[raddr_wide[ADDR_W-1:0]];
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_root       = rsp_root_ff;
   assign rsp_other_root = rsp_other_ff;

   // A result only follows an accepted item or a cycle of work
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy || accept))
      else $error("result strobe without a preceding accept or busy cycle");

   // Fill writes stay below the built modulus
   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_FILL) |-> (step_r < built_mod_ff))
      else $error("fill address at or above modulus");

   // Table becomes built only together with a successful build result
   a_built_with_ok: assert property (@(posedge clock) disable iff (reset)
      $rose(built_ff) |-> (rsp_strobe && (rsp_status == STATUS_OK)))
      else $error("table marked built without an ok result");

   // Error results carry no root
   a_err_zero_root: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != STATUS_OK)) |-> ((rsp_root == '0) && (rsp_other_root == '0)))
      else $error("nonzero root on an error result");

endmodule

[test/tb_modular_square_root_table_top.sv]
`timescale 1ns / 100ps

module tb_modular_square_root_table_top;
   import mst_pkg::*;

   localparam int TABLE_DEPTH     = DEF_TABLE_DEPTH;
   localparam int CLOCK_PERIOD    = 12;
   localparam int TOTAL_ITEMS     = 1450;
   localparam int CALM_TAIL_START = 1300;
   localparam int SETTLE_CYCLES   = 20;

   // One pending entry: either a lookup item or a modulus register write
   typedef struct {
      logic             is_csr;
      logic             action;
      logic [RES_W-1:0] residue;
      logic [MOD_W-1:0] csr_value;
      int               gap;
   } lookup_req_type;

   typedef struct {
      status_type        status;
      logic [ROOT_W-1:0] root;
      logic [MOD_W-1:0]  other_root;
   } root_answer_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_action = ACT_QUERY;
   logic [RES_W-1:0]    req_residue = '0;
   logic                csr_wr_en = 1'b0;
   logic [MOD_W-1:0]    csr_wr_data = '0;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [ROOT_W-1:0]   rsp_root;
   logic [MOD_W-1:0]    rsp_other_root;

   // Shadow copy of the block's table, flags and modulus register
   logic [ENTRY_W-1:0] model_table [TABLE_DEPTH];
   logic               model_built = 1'b0;
   logic [MOD_W-1:0]   model_built_mod = '0;
   logic [MOD_W-1:0]   model_modulus = MOD_RESET;

   lookup_req_type  pending_q[$];
   root_answer_type expected_answers_q[$];

   int fail_count = 0;
   int items_made = 0;
   int gap_left = 0;
   int gap_after_accept = 0;
   int mode_left = 0;
   bit sender_idles = 1'b0;

   modular_square_root_table_top dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_residue    (req_residue),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_root       (rsp_root),
      .rsp_other_root (rsp_other_root)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Compute the answer to one item and advance the shadow state
   function automatic root_answer_type predict_answer(logic action, logic [RES_W-1:0] residue);
      root_answer_type    ans;
      int                 m;
      logic [ENTRY_W-1:0] entry;
      ans.status     = STATUS_OK;
      ans.root       = '0;
      ans.other_root = '0;
      if (action == ACT_BUILD) begin
         m = int'(model_modulus);
         if (m <= int'(MOD_MIN_BAD) || (m % 2) == 0 || m > TABLE_DEPTH) begin
            model_built = 1'b0;
            ans.status  = STATUS_BADMOD;
         end else begin
            for (int i = 0; i < m; i++)
               model_table[i] = NO_ROOT;
            // last root written to a shared index wins
            for (int y = 0; y <= m / 2; y++)
               model_table[(y * y) % m] = ENTRY_W'(y);
            model_built     = 1'b1;
            model_built_mod = MOD_W'(m);
         end
      end else if (!model_built) begin
         ans.status = STATUS_NOTBUILT;
      end else if (residue >= model_built_mod) begin
         ans.status = STATUS_RANGE;
      end else begin
         entry = model_table[residue];
         if (entry == NO_ROOT) begin
            ans.status = STATUS_NONRES;
         end else begin
            ans.root       = entry[ROOT_W-1:0];
            ans.other_root = (entry == '0) ? '0 : model_built_mod - entry;
         end
      end
      return ans;
   endfunction

   // Pick the idle gap after an item: bursty stretches, none near the end
   function automatic int make_gap();
      if (items_made >= CALM_TAIL_START)
         return 0;
      if (mode_left == 0) begin
         sender_idles = ($urandom_range(0, 2) != 0);
         mode_left    = $urandom_range(10, 60);
      end
      mode_left--;
      if (sender_idles && $urandom_range(0, 3) == 0)
         return $urandom_range(1, 18);
      return 0;
   endfunction

   function automatic void add_lookup(logic action, int residue);
      lookup_req_type req;
      req.is_csr    = 1'b0;
      req.action    = action;
      req.residue   = RES_W'(residue);
      req.csr_value = '0;
      req.gap       = make_gap();
      pending_q.push_back(req);
      items_made++;
   endfunction

   function automatic void add_modulus_write(int value);
      lookup_req_type req;
      req.is_csr    = 1'b1;
      req.action    = ACT_QUERY;
      req.residue   = '0;
      req.csr_value = MOD_W'(value);
      req.gap       = 0;
      pending_q.push_back(req);
   endfunction

   // Drive items and register writes; writes wait for the block to drain
   always @(posedge clock) begin : drive_proc
      logic             nxt_start;
      logic             nxt_action;
      logic             nxt_wr_en;
      logic [RES_W-1:0] nxt_residue;
      logic [MOD_W-1:0] nxt_wr_data;
      lookup_req_type   head;
      nxt_start   = start;
      nxt_action  = req_action;
      nxt_residue = req_residue;
      nxt_wr_en   = 1'b0;
      nxt_wr_data = csr_wr_data;
      if (reset) begin
         nxt_start = 1'b0;
         gap_left  = 0;
      end else begin
         // record the item the block took at this edge
         if (start && !busy) begin
            expected_answers_q.push_back(predict_answer(req_action, req_residue));
            nxt_start = 1'b0;
            gap_left  = gap_after_accept;
         end
         if (!nxt_start) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_q.size() > 0) begin
               head = pending_q[0];
               if (!head.is_csr) begin
                  nxt_start        = 1'b1;
                  nxt_action       = head.action;
                  nxt_residue      = head.residue;
                  gap_after_accept = head.gap;
                  void'(pending_q.pop_front());
               end else if (expected_answers_q.size() == 0 && !busy) begin
                  nxt_wr_en     = 1'b1;
                  nxt_wr_data   = head.csr_value;
                  model_modulus = head.csr_value;
                  void'(pending_q.pop_front());
               end
            end
         end
      end
      start       <= nxt_start;
      req_action  <= nxt_action;
      req_residue <= nxt_residue;
      csr_wr_en   <= nxt_wr_en;
      csr_wr_data <= nxt_wr_data;
   end

   // Check each result mid-cycle against the oldest expected answer
   always @(negedge clock) begin : check_proc
      root_answer_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_answers_q.size() == 0) begin
            $error("unexpected item: status %0d root %0d other_root %0d",
                   rsp_status, rsp_root, rsp_other_root);
            fail_count++;
         end else begin
            want = expected_answers_q.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               fail_count++;
            end
            if (rsp_root !== want.root) begin
               $error("root: expected %0d, actual %0d", want.root, rsp_root);
               fail_count++;
            end
            if (rsp_other_root !== want.other_root) begin
               $error("other_root: expected %0d, actual %0d",
                      want.other_root, rsp_other_root);
               fail_count++;
            end
         end
      end
   end

   // Build the stimulus, release reset, wait for the drain and report
   initial begin : stimulus_proc
      int mod_val;
      int gen_mod;
      int sel;
      int n;
      int d;
      int big_left;
      bit gen_built;
      bit first_phase;
      for (int i = 0; i < TABLE_DEPTH; i++)
         model_table[i] = NO_ROOT;

      // queries before any build, then the default modulus of 7
      add_lookup(ACT_QUERY, 0);
      add_lookup(ACT_QUERY, 4095);
      add_lookup(ACT_BUILD, 4095);
      for (int r = 0; r < 7; r++)
         add_lookup(ACT_QUERY, r);
      add_lookup(ACT_QUERY, 7);
      add_lookup(ACT_QUERY, 4095);
      // largest modulus, composite
      add_modulus_write(4095);
      add_lookup(ACT_BUILD, 0);
      add_lookup(ACT_QUERY, 4094);
      add_lookup(ACT_QUERY, 4095);
      add_lookup(ACT_QUERY, 0);
      // rejected moduli: zero, too small, even
      add_modulus_write(0);
      add_lookup(ACT_BUILD, 0);
      add_lookup(ACT_QUERY, 1);
      add_modulus_write(3);
      add_lookup(ACT_BUILD, 0);
      add_modulus_write(8);
      add_lookup(ACT_BUILD, 0);
      // smallest good modulus, then a register change without a rebuild
      add_modulus_write(5);
      add_lookup(ACT_BUILD, 0);
      add_lookup(ACT_QUERY, 4);
      add_modulus_write(13);
      add_lookup(ACT_QUERY, 10);
      add_lookup(ACT_QUERY, 3);

      // random phases: a modulus write, usually a build, then lookups
      mod_val     = 13;
      gen_mod     = 5;
      gen_built   = 1'b1;
      big_left    = 4;
      first_phase = 1'b1;
      while (items_made < TOTAL_ITEMS) begin
         sel = $urandom_range(0, 99);
         if (first_phase) begin
            mod_val = 4093;
         end else if (sel < 6 && big_left > 0) begin
            mod_val = $urandom_range(3800, 4095) | 1;
            big_left--;
         end else if (sel < 11) begin
            mod_val = $urandom_range(0, 3);
         end else if (sel < 16) begin
            mod_val = $urandom_range(0, 2047) * 2;
         end else begin
            mod_val = $urandom_range(2, 150) * 2 + 1;
            // step up to the next prime for about half the phases
            if (sel < 58) begin
               for (d = 3; d * d <= mod_val; d += 2)
                  if (mod_val % d == 0) begin
                     mod_val += 2;
                     d = 1;
                  end
            end
         end
         first_phase = 1'b0;
         add_modulus_write(mod_val);
         if ($urandom_range(0, 99) < 88) begin
            add_lookup(ACT_BUILD, $urandom_range(0, 4095));
            gen_built = (mod_val > 3) && (mod_val % 2 == 1);
            if (gen_built)
               gen_mod = mod_val;
         end
         n = $urandom_range(15, 40);
         repeat (n) begin
            sel = $urandom_range(0, 99);
            if (sel < 5 && mod_val <= 400) begin
               add_lookup(ACT_BUILD, $urandom_range(0, 4095));
               gen_built = (mod_val > 3) && (mod_val % 2 == 1);
               if (gen_built)
                  gen_mod = mod_val;
            end else if (sel < 13 && gen_built) begin
               add_lookup(ACT_QUERY, $urandom_range(gen_mod, 4095));
            end else if (sel < 20 || !gen_built) begin
               add_lookup(ACT_QUERY, $urandom_range(0, 4095));
            end else begin
               add_lookup(ACT_QUERY, $urandom_range(0, gen_mod - 1));
            end
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() > 0 || start || expected_answers_q.size() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("PASS modular_square_root_table_top");
      else
         $display("FAIL modular_square_root_table_top");
      $finish;
   end

   // Stop a hung run
   initial begin : watchdog_proc
      #(CLOCK_PERIOD * 2_000_000);
      $display("FAIL modular_square_root_table_top");
      $finish;
   end

endmodule
